// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL that carries checks (included by the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCKF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/sckf_pkg.sv -----
// Types, codes and the scan code to ASCII table for the scan code key FIFO.
`timescale 1ns / 1ps

package sckf_pkg;

   localparam int COUNT_WIDTH     = 7;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic [7:0] ESC_CODE    = 8'h01;
   localparam logic [7:0] F1_CODE     = 8'h3B;
   localparam logic [7:0] F2_CODE     = 8'h3C;
   localparam logic [7:0] F3_CODE     = 8'h3D;
   localparam logic [7:0] BREAK_FLOOR = 8'd128;

   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_KILL        = 3'd1;
   localparam logic [2:0] ACT_PAUSE_MAIN  = 3'd2;
   localparam logic [2:0] ACT_PAUSE_LEFT  = 3'd3;
   localparam logic [2:0] ACT_PAUSE_RIGHT = 3'd4;
   localparam logic [2:0] ACT_STORED      = 3'd5;

   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [7:0]             scan_code;
      logic [COUNT_WIDTH-1:0] read_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]             action;
      logic [7:0]             character;
      logic                   char_valid;
      logic                   last;
      logic [COUNT_WIDTH-1:0] chars_returned;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_ACTION,
      KIND_STORE,
      KIND_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [2:0]             action;
      logic [7:0]             character;
      logic [COUNT_WIDTH-1:0] limit;
   } cmd_type;

   // Set 1 make code to ASCII; zero means unmapped. Codes past the table are unmapped.
   function automatic logic [7:0] ascii_of_code(input logic [6:0] code);
      logic [7:0] ch;
      unique case (code)
         7'd1:    ch = 8'h1B;
         7'd2:    ch = 8'h31;
         7'd3:    ch = 8'h32;
         7'd4:    ch = 8'h33;
         7'd5:    ch = 8'h34;
         7'd6:    ch = 8'h35;
         7'd7:    ch = 8'h36;
         7'd8:    ch = 8'h37;
         7'd9:    ch = 8'h38;
         7'd10:   ch = 8'h39;
         7'd11:   ch = 8'h30;
         7'd12:   ch = 8'h2D;
         7'd13:   ch = 8'h3D;
         7'd14:   ch = 8'h08;
         7'd15:   ch = 8'h09;
         7'd16:   ch = 8'h71;
         7'd17:   ch = 8'h77;
         7'd18:   ch = 8'h65;
         7'd19:   ch = 8'h72;
         7'd20:   ch = 8'h74;
         7'd21:   ch = 8'h79;
         7'd22:   ch = 8'h75;
         7'd23:   ch = 8'h69;
         7'd24:   ch = 8'h6F;
         7'd25:   ch = 8'h70;
         7'd26:   ch = 8'h5B;
         7'd27:   ch = 8'h5D;
         7'd28:   ch = 8'h0A;
         7'd30:   ch = 8'h61;
         7'd31:   ch = 8'h73;
         7'd32:   ch = 8'h64;
         7'd33:   ch = 8'h66;
         7'd34:   ch = 8'h67;
         7'd35:   ch = 8'h68;
         7'd36:   ch = 8'h6A;
         7'd37:   ch = 8'h6B;
         7'd38:   ch = 8'h6C;
         7'd39:   ch = 8'h3B;
         7'd40:   ch = 8'h27;
         7'd41:   ch = 8'h7C;
         7'd43:   ch = 8'h7C;
         7'd44:   ch = 8'h7A;
         7'd45:   ch = 8'h78;
         7'd46:   ch = 8'h63;
         7'd47:   ch = 8'h76;
         7'd48:   ch = 8'h62;
         7'd49:   ch = 8'h6E;
         7'd50:   ch = 8'h6D;
         7'd51:   ch = 8'h2C;
         7'd52:   ch = 8'h2E;
         7'd53:   ch = 8'h2F;
         7'd55:   ch = 8'h2A;
         7'd57:   ch = 8'h20;
         7'd59:   ch = 8'h11;
         7'd60:   ch = 8'h12;
         7'd61:   ch = 8'h13;
         7'd74:   ch = 8'h2D;
         7'd78:   ch = 8'h2B;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- hw/rtl/sckf_fifo.sv -----
// Small register FIFO used for the command queue and the response queue.
`timescale 1ns / 1ps

module sckf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           din,
   input  logic                       pop,
   output logic [WIDTH-1:0]           dout,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign empty   = (level_ff == '0);
   assign full    = (level_ff == LVL_W'(DEPTH));
   assign level   = level_ff;
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- hw/rtl/sckf_front.sv -----
// Front end: classifies a request into an action, store or read command.
`timescale 1ns / 1ps

module sckf_front #(
   parameter int MAX_READ = 64
) (
   input  sckf_pkg::req_type req,
   output sckf_pkg::cmd_type cmd
);

   logic [7:0] mapped;

   assign mapped = sckf_pkg::ascii_of_code(req.scan_code[6:0]);

   always_comb begin
      cmd           = '0;
      cmd.kind      = sckf_pkg::KIND_ACTION;
      cmd.action    = sckf_pkg::ACT_NONE;
      if (req.mode == sckf_pkg::MODE_READ) begin
         cmd.kind  = sckf_pkg::KIND_READ;
         cmd.limit = (req.read_limit > sckf_pkg::COUNT_WIDTH'(MAX_READ)) ?
                     sckf_pkg::COUNT_WIDTH'(MAX_READ) : req.read_limit;
      end else if (req.scan_code == sckf_pkg::ESC_CODE) begin
         cmd.action = sckf_pkg::ACT_KILL;
      end else if (req.scan_code == sckf_pkg::F1_CODE) begin
         cmd.action = sckf_pkg::ACT_PAUSE_MAIN;
      end else if (req.scan_code == sckf_pkg::F2_CODE) begin
         cmd.action = sckf_pkg::ACT_PAUSE_LEFT;
      end else if (req.scan_code == sckf_pkg::F3_CODE) begin
         cmd.action = sckf_pkg::ACT_PAUSE_RIGHT;
      end else if (req.scan_code < sckf_pkg::BREAK_FLOOR && mapped != 8'h00) begin
         // ring fullness is checked by the back end
         cmd.kind      = sckf_pkg::KIND_STORE;
         cmd.character = mapped;
      end
   end

endmodule

// ----- hw/rtl/sckf_back.sv -----
// Back end: character ring, store and pop sequencing, response staging.
`timescale 1ns / 1ps

module sckf_back #(
   parameter int RING_DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         cmd_empty,
   input  sckf_pkg::cmd_type                            cmd,
   output logic                                         cmd_pop,
   input  logic [$clog2(sckf_pkg::RSP_QUEUE_DEPTH+1)-1:0] rsp_level,
   output logic                                         rsp_push,
   output sckf_pkg::rsp_type                            rsp
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int LVL_W = $clog2(sckf_pkg::RSP_QUEUE_DEPTH + 1);
   localparam int CW    = sckf_pkg::COUNT_WIDTH;

   logic [7:0]       ring_mem [RING_DEPTH];
   logic [7:0]       mem_rdata_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CW-1:0]    taken_ff, taken_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_mem_ff, s1_mem_in;
   sckf_pkg::rsp_type s1_rsp_ff, s1_rsp_in;
   logic             mem_we, mem_re;
   logic             room, go, ring_full, pop_last;

   // credit: queued responses plus the one in the staging register
   assign room      = (LVL_W'(rsp_level) + LVL_W'(s1_valid_ff)) <
                      LVL_W'(sckf_pkg::RSP_QUEUE_DEPTH);
   assign go        = !cmd_empty && room;
   assign ring_full = (fill_ff == CNT_W'(RING_DEPTH));
   assign pop_last  = ((taken_ff + 1'b1) == cmd.limit) || (fill_ff == CNT_W'(1));

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fill_in     = fill_ff;
      taken_in    = taken_ff;
      s1_valid_in = 1'b0;
      s1_mem_in   = 1'b0;
      s1_rsp_in   = '0;
      s1_rsp_in.last = 1'b1;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      if (go) begin
         s1_valid_in = 1'b1;
         case (cmd.kind)
            sckf_pkg::KIND_ACTION: begin
               s1_rsp_in.action = cmd.action;
               cmd_pop          = 1'b1;
            end
            sckf_pkg::KIND_STORE: begin
               cmd_pop = 1'b1;
               if (ring_full) begin
                  s1_rsp_in.action = sckf_pkg::ACT_NONE;
               end else begin
                  s1_rsp_in.action = sckf_pkg::ACT_STORED;
                  mem_we    = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
            end
            sckf_pkg::KIND_READ: begin
               if (taken_ff < cmd.limit && fill_ff != '0) begin
                  mem_re                   = 1'b1;
                  s1_mem_in                = 1'b1;
                  s1_rsp_in.char_valid     = 1'b1;
                  s1_rsp_in.last           = pop_last;
                  s1_rsp_in.chars_returned = pop_last ? taken_ff + 1'b1 : '0;
                  rd_ptr_in = (rd_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
                  fill_in   = fill_ff - 1'b1;
                  if (pop_last) begin
                     cmd_pop  = 1'b1;
                     taken_in = '0;
                  end else begin
                     taken_in = taken_ff + 1'b1;
                  end
               end else begin
                  // nothing to pop: single empty response
                  cmd_pop  = 1'b1;
                  taken_in = '0;
               end
            end
            default: begin
               cmd_pop     = 1'b1;
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
         taken_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
         taken_ff    <= taken_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mem_ff <= s1_mem_in;
      s1_rsp_ff <= s1_rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_ptr_ff] <= cmd.character;
      end
      if (mem_re) begin
         mem_rdata_ff <= ring_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      rsp = s1_rsp_ff;
      if (s1_mem_ff) begin
         rsp.character = mem_rdata_ff;
      end
   end

   assign rsp_push = s1_valid_ff;

endmodule

// ----- hw/rtl/scan_code_key_fifo.sv -----
// Top level of the scan code key FIFO: front end, command queue, back end, response queue.
//
// Requests are either set 1 keyboard scan codes or software read requests. The front end
// classifies each request as it is pushed (Escape and F1 to F3 give an action, break codes
// and unmapped codes give action none, other codes become a store) and places it in a
// two-entry command queue, so req_full only rises when that queue is full. The back end
// owns the character ring (RING_DEPTH entries of memory, written at one address and read at
// one address per cycle, read data registered) and runs one command at a time. An action or
// store command gives one response. A read gives one response per popped character, at
// most MAX_READ of them, and one empty response when nothing is popped; the last response
// carries the count. Responses pass through a staging register into a four-entry response
// queue, and the back end only issues while it holds a free queue credit, so a stalled
// consumer holds the back end, and the two-entry command queue then fills until req_full
// rises. The ring needs no clearing pass after reset: a fill count tells empty and full
// slots apart, so the block takes requests from the first cycle after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scan_code_key_fifo #(
   parameter int RING_DEPTH = 256,
   parameter int MAX_READ   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sckf_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sckf_pkg::rsp_type rsp_data
);

   localparam int CMD_W = $bits(sckf_pkg::cmd_type);
   localparam int RSP_W = $bits(sckf_pkg::rsp_type);
   localparam int CLV_W = $clog2(sckf_pkg::CMD_QUEUE_DEPTH + 1);
   localparam int RLV_W = $clog2(sckf_pkg::RSP_QUEUE_DEPTH + 1);

   sckf_pkg::cmd_type front_cmd;
   sckf_pkg::cmd_type head_cmd;
   sckf_pkg::rsp_type back_rsp;
   logic [CMD_W-1:0]  cmd_dout;
   logic [RSP_W-1:0]  rsp_dout;
   logic              cmd_empty, cmd_full, cmd_pop;
   logic [CLV_W-1:0]  cmd_level;
   logic              rsp_push, rsp_full;
   logic [RLV_W-1:0]  rsp_level;
   logic              req_take;

   assign req_full = cmd_full;
   assign req_take = req_push && !cmd_full;

   sckf_front #(
      .MAX_READ (MAX_READ)
   ) u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   // command queue between classification and execution
   sckf_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (sckf_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_take),
      .din   (front_cmd),
      .pop   (cmd_pop),
      .dout  (cmd_dout),
      .empty (cmd_empty),
      .full  (cmd_full),
      .level (cmd_level)
   );

   assign head_cmd = cmd_dout;

   sckf_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   // response queue; the back end never pushes into a full queue
   sckf_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (sckf_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (back_rsp),
      .pop   (rsp_pop),
      .dout  (rsp_dout),
      .empty (rsp_empty),
      .full  (rsp_full),
      .level (rsp_level)
   );

   assign rsp_data = rsp_dout;

   // credit scheme must keep the response queue from overflowing
   `SCKF_ASSERT_IMP(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_full)
   // back end only retires a command that is there
   `SCKF_ASSERT_IMP(a_cmd_pop_valid, clock, reset, cmd_pop, !cmd_empty)
   // a taken request shows up in the command queue
   `SCKF_ASSERT_NEXT(a_req_queued, clock, reset, req_take, cmd_level != '0)
   // last popped character always reports a nonzero count
   `SCKF_ASSERT_IMP(a_last_count, clock, reset,
      !rsp_empty && rsp_data.last && rsp_data.char_valid, rsp_data.chars_returned != '0)

endmodule

// ----- sim/scan_code_key_fifo_checker.sv -----
// Response checker for the scan code key FIFO: mirrors the character ring and compares.
`timescale 1ns / 1ps

module scan_code_key_fifo_checker #(
   parameter int RING_DEPTH = 256,
   parameter int MAX_READ   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  sckf_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  sckf_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count,
   output int                rsp_count,
   output int                stored_count,
   output int                full_drops
);
   import sckf_pkg::*;

   logic [7:0]  key_ring [RING_DEPTH];
   int unsigned wr_ptr;
   int unsigned rd_ptr;
   rsp_type     expected_rsps [$];
   int          fail_tally;
   int          rsp_tally;
   int          store_tally;
   int          drop_tally;

   // Set 1 make code to ASCII, zero where unmapped or past the table.
   function automatic logic [7:0] set1_ascii(input logic [7:0] code);
      case (code)
         8'd1:  return 8'h1B;
         8'd2:  return "1";
         8'd3:  return "2";
         8'd4:  return "3";
         8'd5:  return "4";
         8'd6:  return "5";
         8'd7:  return "6";
         8'd8:  return "7";
         8'd9:  return "8";
         8'd10: return "9";
         8'd11: return "0";
         8'd12: return "-";
         8'd13: return "=";
         8'd14: return 8'h08;
         8'd15: return 8'h09;
         8'd16: return "q";
         8'd17: return "w";
         8'd18: return "e";
         8'd19: return "r";
         8'd20: return "t";
         8'd21: return "y";
         8'd22: return "u";
         8'd23: return "i";
         8'd24: return "o";
         8'd25: return "p";
         8'd26: return "[";
         8'd27: return "]";
         8'd28: return 8'h0A;
         8'd30: return "a";
         8'd31: return "s";
         8'd32: return "d";
         8'd33: return "f";
         8'd34: return "g";
         8'd35: return "h";
         8'd36: return "j";
         8'd37: return "k";
         8'd38: return "l";
         8'd39: return ";";
         8'd40: return 8'h27;
         8'd41: return "|";
         8'd43: return "|";
         8'd44: return "z";
         8'd45: return "x";
         8'd46: return "c";
         8'd47: return "v";
         8'd48: return "b";
         8'd49: return "n";
         8'd50: return "m";
         8'd51: return ",";
         8'd52: return ".";
         8'd53: return "/";
         8'd55: return "*";
         8'd57: return " ";
         8'd59: return 8'h11;
         8'd60: return 8'h12;
         8'd61: return 8'h13;
         8'd74: return "-";
         8'd78: return "+";
         default: return 8'h00;
      endcase
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_tally++;
      end
   endtask

   task automatic predict_request(input req_type req);
      rsp_type     rsp;
      logic [7:0]  ch;
      int unsigned limit;
      int unsigned popped;
      rsp = '0;
      if (req.mode == MODE_SCAN) begin
         rsp.last = 1'b1;
         ch = set1_ascii(req.scan_code);
         case (req.scan_code)
            ESC_CODE: rsp.action = ACT_KILL;
            F1_CODE:  rsp.action = ACT_PAUSE_MAIN;
            F2_CODE:  rsp.action = ACT_PAUSE_LEFT;
            F3_CODE:  rsp.action = ACT_PAUSE_RIGHT;
            default: begin
               if (req.scan_code < BREAK_FLOOR && ch != 8'h00) begin
                  if (key_ring[wr_ptr] == 8'h00) begin
                     key_ring[wr_ptr] = ch;
                     wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                     rsp.action = ACT_STORED;
                     store_tally++;
                  end else begin
                     drop_tally++;
                  end
               end
            end
         endcase
         expected_rsps.push_back(rsp);
      end else begin
         limit = (req.read_limit > MAX_READ) ? MAX_READ : req.read_limit;
         popped = 0;
         while (popped < limit && key_ring[rd_ptr] != 8'h00) begin
            rsp = '0;
            rsp.character  = key_ring[rd_ptr];
            rsp.char_valid = 1'b1;
            key_ring[rd_ptr] = 8'h00;
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            popped++;
            if (popped == limit || key_ring[rd_ptr] == 8'h00) begin
               rsp.last           = 1'b1;
               rsp.chars_returned = COUNT_WIDTH'(popped);
            end
            expected_rsps.push_back(rsp);
         end
         if (popped == 0) begin
            rsp = '0;
            rsp.last = 1'b1;
            expected_rsps.push_back(rsp);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) key_ring[i] = 8'h00;
         wr_ptr = 0;
         rd_ptr = 0;
         expected_rsps.delete();
         fail_tally  = 0;
         rsp_tally   = 0;
         store_tally = 0;
         drop_tally  = 0;
      end else begin
         // a response can never belong to a request taken at the same edge
         if (rsp_pop && !rsp_empty) begin
            rsp_tally++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: action %0d character %0d last %0d",
                      rsp_data.action, rsp_data.character, rsp_data.last);
               fail_tally++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("action", want.action, rsp_data.action);
               check_field("character", want.character, rsp_data.character);
               check_field("char_valid", want.char_valid, rsp_data.char_valid);
               check_field("last", want.last, rsp_data.last);
               check_field("chars_returned", want.chars_returned,
                           rsp_data.chars_returned);
            end
         end
         if (req_push && !req_full) predict_request(req_data);
      end
      error_count   <= fail_tally;
      pending_count <= expected_rsps.size();
      rsp_count     <= rsp_tally;
      stored_count  <= store_tally;
      full_drops    <= drop_tally;
   end

endmodule

// ----- sim/scan_code_key_fifo_tb.sv -----
// Testbench top for the scan code key FIFO: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module scan_code_key_fifo_tb;
   import sckf_pkg::*;

   localparam int RING_DEPTH   = 256;
   localparam int MAX_READ     = 64;
   localparam int CLOCK_PERIOD = 12;     // ns
   localparam int RESET_CYCLES = 12;
   localparam int PHASE_ITEMS  = 34;     // random requests per idle mix
   localparam int HOLD_KEYS    = 16;     // keys offered while the consumer is held off
   localparam int HOLD_CYCLES  = 300;    // long consumer stall while the queues back up
   localparam int DRAIN_CYCLES = 50;     // settle time once nothing is outstanding
   // Worst case is every request popping MAX_READ characters at 64 % stall, plus
   // the hold; this leaves a wide margin.
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        req_full;
   req_type     req_data  = '0;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   rsp_type     rsp_data;

   int          error_count;
   int          pending_count;
   int          rsp_count;
   int          stored_count;
   int          full_drops;
   int          request_count = 0;
   int unsigned cycle_count   = 0;

   // Idle mix, in percent, for the producer and the consumer side
   int unsigned send_idle_pct = 0;
   int unsigned pop_stall_pct = 0;

   // Long hold-off: the stimulus bumps hold_trigger, the consumer process owns the count
   int unsigned hold_trigger = 0;
   int unsigned hold_seen    = 0;
   int unsigned hold_left    = 0;

   scan_code_key_fifo #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_READ   (MAX_READ)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   scan_code_key_fifo_checker #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_READ   (MAX_READ)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count),
      .stored_count  (stored_count),
      .full_drops    (full_drops)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Hard stop if the block hangs or loses a response
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_count);
      $display("simulation failed");
      $finish;
   end

   // Consumer side: random stalls, or a long hold-off when the stimulus asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_pop   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Scan code request; read_limit carries junk, which the block must ignore
   function automatic req_type scan_req(input logic [7:0] code);
      req_type req;
      req.mode       = MODE_SCAN;
      req.scan_code  = code;
      req.read_limit = COUNT_WIDTH'($urandom_range(127));
      return req;
   endfunction

   // Read request; scan_code carries junk likewise
   function automatic req_type read_req(input logic [COUNT_WIDTH-1:0] limit);
      req_type req;
      req.mode       = MODE_READ;
      req.scan_code  = 8'($urandom_range(255));
      req.read_limit = limit;
      return req;
   endfunction

   // Letters, digits, punctuation and Enter only: every code here becomes a store
   function automatic logic [7:0] pick_key_code();
      case ($urandom_range(2))
         0:       return 8'($urandom_range(13, 2));
         1:       return 8'($urandom_range(28, 16));
         default: return 8'($urandom_range(53, 44));
      endcase
   endfunction

   // Mostly keystrokes and small reads so characters flow through the ring,
   // with a share of noise: specials, break codes, unmapped codes, odd limits.
   function automatic req_type random_req();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) return scan_req(pick_key_code());
      if (pick < 75) begin
         if ($urandom_range(7) == 0) return read_req(COUNT_WIDTH'($urandom_range(127)));
         return read_req(COUNT_WIDTH'($urandom_range(8, 1)));
      end
      return scan_req(8'($urandom_range(255)));
   endfunction

   // Offer one request and return at the edge that takes it. push stays high on
   // return, so back-to-back requests never drop it within a time step.
   task automatic push_request(input req_type req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_full);
      request_count++;
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: read of an empty ring, the four special keys
      push_request(read_req(7'd5));
      push_request(scan_req(ESC_CODE));
      push_request(scan_req(F1_CODE));
      push_request(scan_req(F2_CODE));
      push_request(scan_req(F3_CODE));
      // break codes, lowest and highest
      push_request(scan_req(BREAK_FLOOR));
      push_request(scan_req(8'hFF));
      // unmapped: zero entry, hole in the table, an index past it, top make code
      push_request(scan_req(8'h00));
      push_request(scan_req(8'h1D));
      push_request(scan_req(8'h5A));
      push_request(scan_req(8'h7F));
      // mapped keys, including the sparse tail of the table
      push_request(scan_req(8'h02));
      push_request(scan_req(8'h10));
      push_request(scan_req(8'h39));
      push_request(scan_req(8'h4E));
      push_request(scan_req(8'h4A));
      push_request(scan_req(8'h35));
      // zero limit with characters waiting, a partial read, a saturated limit
      push_request(read_req(7'd0));
      push_request(read_req(7'd2));
      push_request(read_req(7'd127));
      push_request(scan_req(8'h1E));
      push_request(scan_req(8'h1C));
      push_request(read_req(7'd64));
      push_request(read_req(7'd65));

      // Keys keep coming with the consumer held off: the response and command
      // queues back up and req_full stalls the producer. A special key and a
      // capped read then follow once the hold ends.
      hold_trigger <= hold_trigger + 1;
      for (int i = 0; i < HOLD_KEYS; i++) push_request(scan_req(pick_key_code()));
      push_request(scan_req(F1_CODE));
      push_request(read_req(COUNT_WIDTH'(MAX_READ)));

      // Random traffic under four idle mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 0;
               pop_stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 64;
               pop_stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               pop_stall_pct <= 64;
            end
            default: begin
               send_idle_pct <= 15;
               pop_stall_pct <= 15;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) push_request(random_req());
      end

      // Flush up to MAX_READ characters still in the ring so the tail is checked too
      push_request(read_req(7'd127));

      req_push      <= 1'b0;
      pop_stall_pct <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d requests, %0d responses, %0d characters stored, %0d full drops.",
               request_count, rsp_count, stored_count, full_drops);
      $display("Covered special, break and unmapped keys, empty, partial and capped reads, stalls.");
      if (error_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
